FILE: src/sfl_pkg.sv
// shared constants for the stereo flanger
package sfl_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH = 3'd4;

    localparam int PHASE_BITS = 32;
    localparam int WIDTH_BITS = 20;
    localparam int GAIN_BITS = 16;
    localparam int LENGTH_BITS = 13;

    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = 32'd44739;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RST = 20'd122880;
    localparam logic [GAIN_BITS-1:0] FEEDBACK_RST = 16'd0;
    localparam logic [GAIN_BITS-1:0] DEPTH_RST = 16'd32768;
    localparam logic [LENGTH_BITS-1:0] LENGTH_RST = 13'd960;

    // serial multiplier operand b width and delay width
    localparam int MUL_B_BITS = 17;
    localparam int DELAY_BITS = 21;

    localparam logic [MUL_B_BITS-1:0] UNITY = 17'd32768;
    localparam logic [MUL_B_BITS-1:0] SIN_A = 17'd51472;
    localparam logic [MUL_B_BITS-1:0] SIN_B = 17'd21024;
    localparam logic [MUL_B_BITS-1:0] SIN_C = 17'd2320;

endpackage

FILE: src/sfl_ram.sv
// generic single-write, single-read ram with registered read
module sfl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/sfl_serial_mul.sv
// bit-serial shift-add multiplier, signed a times unsigned b
module sfl_serial_mul #(
    parameter int AW = 21,
    parameter int BW = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [AW-1:0] a,
    input  logic [BW-1:0]        b,
    output logic                 done,
    output logic signed [AW+BW-1:0] p
);

    localparam int CW = $clog2(BW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic signed [AW-1:0] a_reg;
    logic [BW-1:0]     b_reg;
    logic signed [AW:0] hi_reg;
    logic [BW-1:0]     lo_reg;
    logic signed [AW:0] sum;

    assign sum = hi_reg + (b_reg[0] ? {a_reg[AW-1], a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(BW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= b;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[AW], sum[AW:1]};
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
            b_reg  <= {1'b0, b_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign p = {hi_reg[AW-1:0], lo_reg};

endmodule

FILE: src/stereo_flanger.sv
// stereo flanger top level: lfo, delay lines, interpolation and mixing
//
//  channel  direction  handshake          payload
//  s_*      in         tvalid/tready      in_left, in_right
//  m_*      out        tvalid/tready      out_left, out_right
//  cfg_*    in         wen, no wait       register index and data
//
// between one accept and the next, a stereo pair passes thirteen multiplies
// (17 steps each) on one shared shift-add unit, a 21-step delay reduction
// and the states for position, ram reads, write-back and accept
// after reset a clearing pass zeroes every word of the line ram; no
// transaction is taken meanwhile
// a finished result waits in the output register; the next pair is taken
// at once and stalls only at write-back if that result is still unclaimed
module stereo_flanger #(
    parameter int LINE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 24,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // in_left, in_right
    output logic m_tvalid,
    input  logic m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata, // out_left, out_right
    input  logic cfg_wen,
    input  logic [sfl_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [sfl_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int TW = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int IW = $clog2(LINE_DEPTH);
    localparam int LW = IW + 1;
    localparam int PW = LW + 8;
    localparam int SL = $clog2(SINE_ENTRIES);
    localparam int MA = ((SB > 20) ? SB : 20) + 1;
    localparam int MB = sfl_pkg::MUL_B_BITS;
    localparam int PRW = MA + MB;
    localparam int DW = sfl_pkg::DELAY_BITS;
    localparam int DCW = $clog2(DW);
    localparam int IPW = SB + 9;
    localparam logic signed [SB+1:0] SMAX = {3'b000, {(SB-1){1'b1}}};
    localparam logic signed [SB+1:0] SMIN = {3'b111, {(SB-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_ZZ, ST_CZ, ST_ZT, ST_ZA, ST_WS, ST_MOD, ST_POS,
        ST_RPREV, ST_RNEXT, ST_RDATA, ST_LN, ST_LP, ST_RN, ST_RP,
        ST_LF, ST_LD, ST_RF, ST_RD, ST_WB
    } state_t;

    function automatic logic signed [SB-1:0] sat(input logic signed [SB+1:0] v);
        logic signed [SB+1:0] r;
        r = v;
        if (v > SMAX)
        begin
            r = SMAX;
        end
        else if (v < SMIN)
        begin
            r = SMIN;
        end
        return r[SB-1:0];
    endfunction

    function automatic logic signed [MA-1:0] sext_a(input logic signed [SB-1:0] v);
        return {{(MA-SB){v[SB-1]}}, v};
    endfunction

    function automatic logic signed [MA-1:0] zext_a(input logic [MB-1:0] v);
        return {{(MA-MB){1'b0}}, v};
    endfunction

    state_t state_reg;

    logic [sfl_pkg::PHASE_BITS-1:0]  phase_step_reg;
    logic [sfl_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [sfl_pkg::GAIN_BITS-1:0]   feedback_reg;
    logic [sfl_pkg::GAIN_BITS-1:0]   depth_reg;
    logic [sfl_pkg::LENGTH_BITS-1:0] length_reg;
    logic [IW-1:0]                   w_reg;
    logic [sfl_pkg::PHASE_BITS-1:0]  phase_reg;
    logic [IW-1:0]                   clr_reg;

    logic signed [SB-1:0] x_l_reg, x_r_reg;
    logic [15:0]          z_reg;
    logic [1:0]           quad_reg;
    logic [MB-1:0]        z2_reg;
    logic [DW-1:0]        dly_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic [PW-1:0]        rem_reg;
    logic [IW-1:0]        prev_reg, next_reg;
    logic [7:0]           frac_reg;
    logic signed [SB-1:0] pl_reg, pr_reg, nr_reg;
    logic signed [IPW-1:0] pn_reg;
    logic signed [SB-1:0] dl_l_reg, dl_r_reg;
    logic signed [SB-1:0] st_l_reg, st_r_reg, y_l_reg, y_r_reg;
    logic [2*SB-1:0]      out_reg;
    logic                 out_valid_reg;

    logic                 mul_start_reg;
    logic signed [MA-1:0] mul_a_reg;
    logic [MB-1:0]        mul_b_reg;
    logic                 mul_done;
    logic signed [PRW-1:0] mul_p;

    logic [LW-1:0]  len_eff;
    logic [IW-1:0]  w_eff;
    logic [IW-1:0]  w_inc;
    logic [MB-1:0]  fb_eff, dp_eff;
    logic [MB-1:0]  p_sh15;
    logic signed [PRW-1:0] p_floor15;
    logic signed [SB+1:0]  term15;
    logic [SL-1:0]  sine_idx;
    logic [MB-1:0]  sine_pos;
    logic [15:0]    z_in;
    logic [PW-1:0]  mod_len;
    logic [PW:0]    trial;
    logic [LW:0]    wl;
    logic [LW-1:0]  wl_red;
    logic [PW-1:0]  amod;
    logic [PW-1:0]  pos;
    logic [LW-1:0]  prev_w, next_w;
    logic signed [IPW-1:0] interp_sum;
    logic [MB-1:0]  frac_inv;
    logic           wb_fire;
    logic           ram_we;
    logic [IW-1:0]  ram_wr_addr;
    logic [2*SB-1:0] ram_wr_data, ram_rd_data;
    logic [IW-1:0]  ram_rd_addr;

    always_comb
    begin
        if (length_reg < sfl_pkg::LENGTH_BITS'(4))
        begin
            len_eff = LW'(4);
        end
        else if (32'(length_reg) > LINE_DEPTH)
        begin
            len_eff = LW'(LINE_DEPTH);
        end
        else
        begin
            len_eff = LW'(length_reg);
        end
    end

    assign w_eff = (LW'(w_reg) >= len_eff) ? '0 : w_reg;
    assign w_inc = (LW'(w_eff) + LW'(1) >= len_eff) ? '0 : w_eff + IW'(1);
    assign fb_eff = (feedback_reg > 16'd32768) ? sfl_pkg::UNITY : MB'(feedback_reg);
    assign dp_eff = (depth_reg > 16'd32768) ? sfl_pkg::UNITY : MB'(depth_reg);

    assign p_sh15 = mul_p[15 +: MB];
    assign p_floor15 = mul_p >>> 15;
    assign term15 = p_floor15[SB+1:0];

    // quarter-wave position of the lfo phase
    assign sine_idx = phase_reg[sfl_pkg::PHASE_BITS-1 -: SL];
    assign sine_pos = MB'(sine_idx) << (MB - SL);
    assign z_in = sine_pos[15] ? (16'd32768 - {1'b0, sine_pos[14:0]})
                               : {1'b0, sine_pos[14:0]};

    // delay reduction modulo the active length
    assign mod_len = {len_eff, 8'd0};
    assign trial = {rem_reg, dly_reg[DW-1]};

    assign wl = (LW+1)'(w_eff) + (LW+1)'(len_eff) - (LW+1)'(3);
    assign wl_red = (wl >= (LW+1)'(len_eff)) ? LW'(wl - (LW+1)'(len_eff)) : LW'(wl);
    assign amod = {wl_red, 8'd0};
    assign pos = (amod >= rem_reg) ? amod - rem_reg : amod + mod_len - rem_reg;
    assign prev_w = pos[PW-1:8];
    assign next_w = (prev_w + LW'(1) == len_eff) ? '0 : prev_w + LW'(1);

    assign interp_sum = pn_reg + mul_p[IPW-1:0];
    assign frac_inv = MB'(256) - MB'(frac_reg);

    assign wb_fire = (state_reg == ST_WB) && (!out_valid_reg || m_tready);

    assign ram_we = (state_reg == ST_CLEAR) || wb_fire;
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? clr_reg : w_eff;
    assign ram_wr_data = (state_reg == ST_CLEAR) ? '0 : {st_r_reg, st_l_reg};
    assign ram_rd_addr = (state_reg == ST_RNEXT) ? next_reg : prev_reg;

    sfl_ram #(
        .WIDTH(2*SB),
        .DEPTH(LINE_DEPTH)
    ) u_line (
        .clk(clk),
        .we(ram_we),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    sfl_serial_mul #(
        .AW(MA),
        .BW(MB)
    ) u_mul (
        .clk(clk),
        .rst_n(rst_n),
        .start(mul_start_reg),
        .a(mul_a_reg),
        .b(mul_b_reg),
        .done(mul_done),
        .p(mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            phase_step_reg <= sfl_pkg::PHASE_STEP_RST;
            width_reg      <= sfl_pkg::WIDTH_RST;
            feedback_reg   <= sfl_pkg::FEEDBACK_RST;
            depth_reg      <= sfl_pkg::DEPTH_RST;
            length_reg     <= sfl_pkg::LENGTH_RST;
            w_reg          <= '0;
            phase_reg      <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            mul_start_reg  <= 1'b0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            x_l_reg        <= '0;
            x_r_reg        <= '0;
            z_reg          <= '0;
            quad_reg       <= '0;
            z2_reg         <= '0;
            dly_reg        <= '0;
            dcnt_reg       <= '0;
            rem_reg        <= '0;
            prev_reg       <= '0;
            next_reg       <= '0;
            frac_reg       <= '0;
            pl_reg         <= '0;
            pr_reg         <= '0;
            nr_reg         <= '0;
            pn_reg         <= '0;
            dl_l_reg       <= '0;
            dl_r_reg       <= '0;
            st_l_reg       <= '0;
            st_r_reg       <= '0;
            y_l_reg        <= '0;
            y_r_reg        <= '0;
            out_reg        <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;

            if (m_tvalid && m_tready && !wb_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wen)
            begin
                unique case (cfg_index)
                    sfl_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data;
                    sfl_pkg::REG_WIDTH:
                        width_reg <= cfg_data[sfl_pkg::WIDTH_BITS-1:0];
                    sfl_pkg::REG_FEEDBACK:
                        feedback_reg <= cfg_data[sfl_pkg::GAIN_BITS-1:0];
                    sfl_pkg::REG_DEPTH:
                        depth_reg <= cfg_data[sfl_pkg::GAIN_BITS-1:0];
                    sfl_pkg::REG_LENGTH:
                    begin
                        length_reg <= cfg_data[sfl_pkg::LENGTH_BITS-1:0];
                        w_reg      <= '0;
                    end
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + IW'(1);
                    if (clr_reg == IW'(LINE_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        x_l_reg       <= s_tdata[SB-1:0];
                        x_r_reg       <= s_tdata[2*SB-1:SB];
                        z_reg         <= z_in;
                        quad_reg      <= sine_pos[16:15];
                        mul_a_reg     <= zext_a(MB'(z_in));
                        mul_b_reg     <= MB'(z_in);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_ZZ;
                    end
                end
                ST_ZZ:
                begin
                    if (mul_done)
                    begin
                        z2_reg        <= p_sh15;
                        mul_a_reg     <= zext_a(sfl_pkg::SIN_C);
                        mul_b_reg     <= p_sh15;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_CZ;
                    end
                end
                ST_CZ:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg     <= zext_a(z2_reg);
                        mul_b_reg     <= sfl_pkg::SIN_B - p_sh15;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_ZT;
                    end
                end
                ST_ZT:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg     <= zext_a(MB'(z_reg));
                        mul_b_reg     <= sfl_pkg::SIN_A - p_sh15;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_ZA;
                    end
                end
                ST_ZA:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg     <= {{(MA-sfl_pkg::WIDTH_BITS){1'b0}}, width_reg};
                        mul_b_reg     <= quad_reg[1] ? sfl_pkg::UNITY - p_sh15
                                                     : sfl_pkg::UNITY + p_sh15;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_WS;
                    end
                end
                ST_WS:
                begin
                    if (mul_done)
                    begin
                        dly_reg   <= mul_p[16 +: DW];
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD:
                begin
                    if (trial >= {1'b0, mod_len})
                    begin
                        rem_reg <= PW'(trial - {1'b0, mod_len});
                    end
                    else
                    begin
                        rem_reg <= trial[PW-1:0];
                    end
                    dly_reg  <= {dly_reg[DW-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (dcnt_reg == DCW'(DW - 1))
                    begin
                        state_reg <= ST_POS;
                    end
                end
                ST_POS:
                begin
                    prev_reg  <= prev_w[IW-1:0];
                    next_reg  <= next_w[IW-1:0];
                    frac_reg  <= pos[7:0];
                    state_reg <= ST_RPREV;
                end
                ST_RPREV:
                begin
                    state_reg <= ST_RNEXT;
                end
                ST_RNEXT:
                begin
                    pl_reg    <= ram_rd_data[SB-1:0];
                    pr_reg    <= ram_rd_data[2*SB-1:SB];
                    state_reg <= ST_RDATA;
                end
                ST_RDATA:
                begin
                    nr_reg        <= ram_rd_data[2*SB-1:SB];
                    mul_a_reg     <= sext_a(ram_rd_data[SB-1:0]);
                    mul_b_reg     <= MB'(frac_reg);
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_LN;
                end
                ST_LN:
                begin
                    if (mul_done)
                    begin
                        pn_reg        <= mul_p[IPW-1:0];
                        mul_a_reg     <= sext_a(pl_reg);
                        mul_b_reg     <= frac_inv;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_LP;
                    end
                end
                ST_LP:
                begin
                    if (mul_done)
                    begin
                        dl_l_reg      <= interp_sum[SB+7:8];
                        mul_a_reg     <= sext_a(nr_reg);
                        mul_b_reg     <= MB'(frac_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_RN;
                    end
                end
                ST_RN:
                begin
                    if (mul_done)
                    begin
                        pn_reg        <= mul_p[IPW-1:0];
                        mul_a_reg     <= sext_a(pr_reg);
                        mul_b_reg     <= frac_inv;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_RP;
                    end
                end
                ST_RP:
                begin
                    if (mul_done)
                    begin
                        dl_r_reg      <= interp_sum[SB+7:8];
                        mul_a_reg     <= sext_a(dl_l_reg);
                        mul_b_reg     <= fb_eff;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_LF;
                    end
                end
                ST_LF:
                begin
                    if (mul_done)
                    begin
                        st_l_reg      <= sat({{2{x_l_reg[SB-1]}}, x_l_reg} + term15);
                        mul_a_reg     <= sext_a(dl_l_reg);
                        mul_b_reg     <= dp_eff;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_LD;
                    end
                end
                ST_LD:
                begin
                    if (mul_done)
                    begin
                        y_l_reg       <= sat({{2{x_l_reg[SB-1]}}, x_l_reg} + term15);
                        mul_a_reg     <= sext_a(dl_r_reg);
                        mul_b_reg     <= fb_eff;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_RF;
                    end
                end
                ST_RF:
                begin
                    if (mul_done)
                    begin
                        st_r_reg      <= sat({{2{x_r_reg[SB-1]}}, x_r_reg} + term15);
                        mul_a_reg     <= sext_a(dl_r_reg);
                        mul_b_reg     <= dp_eff;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    if (mul_done)
                    begin
                        y_r_reg   <= sat({{2{x_r_reg[SB-1]}}, x_r_reg} + term15);
                        state_reg <= ST_WB;
                    end
                end
                ST_WB:
                begin
                    if (wb_fire)
                    begin
                        out_reg       <= {y_r_reg, y_l_reg};
                        out_valid_reg <= 1'b1;
                        w_reg         <= w_inc;
                        phase_reg     <= phase_reg + phase_step_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = TW'(out_reg);

endmodule
